// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the NTP monitor.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NTPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ntpm assertion failed");

// Condition that must never be true outside reset.
`define NTPM_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ntpm forbidden condition seen");

`endif

// ----- rtl/ntpm_pkg.sv -----
// Types and constants of the NTP time jump and stale monitor.
// No dependencies; used by the conversion, jump check and top-level files.
package ntpm_pkg;

  // Seconds from 1900-01-01 to 1970-01-01.
  localparam logic [31:0] UNIX_EPOCH_OFFSET = 32'd2208988800;
  localparam logic [9:0]  MS_PER_SEC        = 10'd1000;

  localparam logic KIND_TICK      = 1'b0;
  localparam logic KIND_TIMESTAMP = 1'b1;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_SERVER_IP   = 2'd0;
  localparam logic [1:0] REG_JUMP_LIMIT  = 2'd1;
  localparam logic [1:0] REG_STALE_LIMIT = 2'd2;

  localparam logic [30:0] JUMP_LIMIT_RST  = 31'd5;
  localparam logic [15:0] STALE_LIMIT_RST = 16'd10;

  typedef struct packed {
    logic [31:0] seconds;
    logic [9:0]  millis;
  } ntpm_time_t;

endpackage

// ----- rtl/ntpm_convert.sv -----
// Converts an NTP transmit timestamp into Unix seconds and milliseconds.
// Depends on ntpm_pkg.
module ntpm_convert (
  input  logic [31:0]         ntp_seconds,
  input  logic [31:0]         ntp_fraction,
  output ntpm_pkg::ntpm_time_t unix_time
);

  logic [41:0] frac_scaled;

  // The top ten bits of fraction * 1000 give whole milliseconds, always below 1000.
  assign frac_scaled        = {10'd0, ntp_fraction} * {32'd0, ntpm_pkg::MS_PER_SEC};
  assign unix_time.millis   = frac_scaled[41:32];
  assign unix_time.seconds  = ntp_seconds - ntpm_pkg::UNIX_EPOCH_OFFSET;

endmodule

// ----- rtl/ntpm_jump_check.sv -----
// Decides whether a new time differs from the held time by more than the
// jump limit in whole seconds, truncated toward zero. Depends on ntpm_pkg.
module ntpm_jump_check (
  input  ntpm_pkg::ntpm_time_t new_time,
  input  ntpm_pkg::ntpm_time_t old_time,
  input  logic [30:0]          jump_limit,
  output logic                 over_limit
);

  logic [32:0] sec_fwd;
  logic [31:0] sec_back;
  logic [31:0] sec_abs;
  logic        sec_neg;
  logic        ms_lt;
  logic        ms_gt;
  logic        diff_neg;
  logic        borrow;
  logic [32:0] limit_adj;

  assign sec_fwd  = {1'b0, new_time.seconds} - {1'b0, old_time.seconds};
  assign sec_back = old_time.seconds - new_time.seconds;
  assign sec_neg  = sec_fwd[32];
  assign sec_abs  = sec_neg ? sec_back : sec_fwd[31:0];
  assign ms_lt    = new_time.millis < old_time.millis;
  assign ms_gt    = new_time.millis > old_time.millis;

  // When the millisecond part pulls against the sign of the whole step, the
  // truncated magnitude is one second less than the seconds difference.
  assign diff_neg  = sec_neg || ((sec_abs == 32'd0) && ms_lt);
  assign borrow    = diff_neg ? ms_gt : ms_lt;
  assign limit_adj = {2'b00, jump_limit} + {32'd0, borrow};

  assign over_limit = {1'b0, sec_abs} > limit_adj;

endmodule

// ----- rtl/ntp_time_jump_and_stale_monitor_core.sv -----
// NTP time jump and stale monitor: top level.
// Depends on ntpm_pkg, ntpm_convert and ntpm_jump_check.
//
// Usage: each transfer on the in_ channel is a timer tick (in_kind 0) or an
// NTP transmit timestamp with its sender address (in_kind 1). Every input
// transfer yields exactly one transfer on the out_ channel carrying the
// accepted, jump and stale flags and the held Unix time after that item.
// Timestamps from an address other than server_ip are dropped without any
// change of state. Registers are written through the cfg_ APB port at byte
// addresses 0 (server_ip), 4 (jump limit) and 8 (stale limit).
// Flow: an item taken into the input register passes on to the result register
// and is presented on out_. Throughput is one item per cycle while the receiver
// does not stall; the input register feeds a single pass of conversion, one
// 32x10 multiply, a 33-bit difference and compare, straight into the result
// register and the held-time state.
// Reset clears both stages, drops the held time, restores register defaults
// and arms first-sample mode. When the receiver stalls, the result register
// holds its transfer and one further item waits in the input register;
// in_ready falls only when both are full.
module ntp_time_jump_and_stale_monitor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_source_ip,
  input  logic [31:0] in_ntp_seconds,
  input  logic [31:0] in_ntp_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic        out_jump,
  output logic        out_stale,
  output logic [31:0] out_unix_seconds,
  output logic [9:0]  out_millis,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic [31:0] server_ip_r;
  logic [30:0] jump_limit_r;
  logic [15:0] stale_limit_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  // Input stage.
  logic        s1_valid_r;
  logic        s1_kind_r;
  logic [31:0] s1_source_ip_r;
  logic [31:0] s1_ntp_seconds_r;
  logic [31:0] s1_ntp_fraction_r;
  logic        advance;

  // Monitor state.
  ntpm_pkg::ntpm_time_t held_r;
  ntpm_pkg::ntpm_time_t held_nxt;
  logic                 held_valid_r;
  logic                 held_valid_nxt;
  ntpm_pkg::ntpm_time_t watched_r;
  ntpm_pkg::ntpm_time_t watched_nxt;
  logic                 watched_valid_r;
  logic                 watched_valid_nxt;
  logic [16:0]          ticks_r;
  logic [16:0]          ticks_nxt;
  logic                 rearm_r;
  logic                 rearm_nxt;

  // Result stage.
  logic        out_valid_r;
  logic        out_accepted_r;
  logic        out_jump_r;
  logic        out_stale_r;
  logic        stale_nxt;
  logic        jump_nxt;

  ntpm_pkg::ntpm_time_t new_time;
  logic                 over_limit;
  logic                 is_tick;
  logic                 take;
  logic                 held_eq;
  logic [16:0]          ticks_inc;
  logic                 stale_hit;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      ntpm_pkg::REG_SERVER_IP:   cfg_prdata = server_ip_r;
      ntpm_pkg::REG_JUMP_LIMIT:  cfg_prdata = {1'b0, jump_limit_r};
      ntpm_pkg::REG_STALE_LIMIT: cfg_prdata = {16'd0, stale_limit_r};
      default:                   cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_ip_r   <= 32'd0;
      jump_limit_r  <= ntpm_pkg::JUMP_LIMIT_RST;
      stale_limit_r <= ntpm_pkg::STALE_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ntpm_pkg::REG_SERVER_IP:   server_ip_r   <= cfg_pwdata;
        ntpm_pkg::REG_JUMP_LIMIT:  jump_limit_r  <= cfg_pwdata[30:0];
        ntpm_pkg::REG_STALE_LIMIT: stale_limit_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r         <= in_kind;
      s1_source_ip_r    <= in_source_ip;
      s1_ntp_seconds_r  <= in_ntp_seconds;
      s1_ntp_fraction_r <= in_ntp_fraction;
    end
  end

  // ---------------- single pass ----------------
  ntpm_convert u_convert (
    .ntp_seconds  (s1_ntp_seconds_r),
    .ntp_fraction (s1_ntp_fraction_r),
    .unix_time    (new_time)
  );

  ntpm_jump_check u_jump_check (
    .new_time   (new_time),
    .old_time   (held_r),
    .jump_limit (jump_limit_r),
    .over_limit (over_limit)
  );

  assign is_tick = s1_kind_r == ntpm_pkg::KIND_TICK;
  assign take    = advance && (s1_kind_r == ntpm_pkg::KIND_TIMESTAMP)
                   && (s1_source_ip_r == server_ip_r);

  // Two times without a value compare equal; a held value never equals none.
  assign held_eq = (!held_valid_r || !watched_valid_r) ?
                   (held_valid_r == watched_valid_r) : (held_r == watched_r);

  assign ticks_inc = ticks_r + 17'd1;
  assign stale_hit = ticks_inc > {1'b0, stale_limit_r};

  always_comb begin
    held_nxt          = held_r;
    held_valid_nxt    = held_valid_r;
    watched_nxt       = watched_r;
    watched_valid_nxt = watched_valid_r;
    ticks_nxt         = ticks_r;
    rearm_nxt         = rearm_r;
    stale_nxt         = 1'b0;
    jump_nxt          = 1'b0;
    if (advance && is_tick) begin
      if (held_eq) begin
        stale_nxt = stale_hit;
        ticks_nxt = stale_hit ? 17'd0 : ticks_inc;
      end else begin
        watched_nxt       = held_r;
        watched_valid_nxt = held_valid_r;
        ticks_nxt         = 17'd0;
      end
    end
    if (take) begin
      // The first sample after reset or a server change is taken unchecked.
      jump_nxt       = !rearm_r && held_valid_r && over_limit;
      rearm_nxt      = 1'b0;
      held_nxt       = new_time;
      held_valid_nxt = 1'b1;
    end
    if (cfg_wr && (cfg_idx == ntpm_pkg::REG_SERVER_IP)) begin
      rearm_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r          <= '0;
      held_valid_r    <= 1'b0;
      watched_r       <= '0;
      watched_valid_r <= 1'b0;
      ticks_r         <= 17'd0;
      rearm_r         <= 1'b1;
    end else begin
      held_r          <= held_nxt;
      held_valid_r    <= held_valid_nxt;
      watched_r       <= watched_nxt;
      watched_valid_r <= watched_valid_nxt;
      ticks_r         <= ticks_nxt;
      rearm_r         <= rearm_nxt;
    end
  end

  // ---------------- result stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The held time is kept at zero until the first sample, so it can be shown as is.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_accepted_r <= take;
      out_jump_r     <= jump_nxt;
      out_stale_r    <= stale_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = out_accepted_r;
  assign out_jump         = out_jump_r;
  assign out_stale        = out_stale_r;
  assign out_unix_seconds = held_r.seconds;
  assign out_millis       = held_r.millis;

endmodule

// ----- rtl/ntpm_checker.sv -----
// Port-level checks of the NTP monitor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ntpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_accepted,
  input logic        out_jump,
  input logic        out_stale,
  input logic [31:0] out_unix_seconds,
  input logic [9:0]  out_millis
);

  logic [44:0] out_data;

  assign out_data = {out_accepted, out_jump, out_stale, out_unix_seconds, out_millis};

  // A stalled result keeps its flags and time.
  `NTPM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `NTPM_NEVER(a_jump_needs_accept, clk, rst_n, out_valid && out_jump && !out_accepted)
  `NTPM_NEVER(a_stale_on_tick_only, clk, rst_n, out_valid && out_stale && out_accepted)
  `NTPM_NEVER(a_millis_range, clk, rst_n, out_valid && (out_millis > 10'd999))

endmodule

bind ntp_time_jump_and_stale_monitor_core ntpm_checker u_ntpm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_accepted     (out_accepted),
  .out_jump         (out_jump),
  .out_stale        (out_stale),
  .out_unix_seconds (out_unix_seconds),
  .out_millis       (out_millis)
);
